[sv/scc_pkg.sv]
// Shared types and constants for the serial command clock.
// Used by the front, queue, back and top-level modules; no dependencies.
package scc_pkg;

  localparam int LINE_CAPACITY_DEFAULT = 64;
  localparam int KEPT_BYTES = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int LABEL_CHARS = 3;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_TWO   = 8'h32;
  localparam logic [7:0] CHAR_FIVE  = 8'h35;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;

  localparam int TIME_KEY_LEN = 8;
  localparam int TEXT_KEY_LEN = 7;
  localparam logic [0:TIME_KEY_LEN-1][7:0] TIME_KEY = "SETTIME=";
  localparam logic [0:TEXT_KEY_LEN-1][7:0] TEXT_KEY = "SETTXT=";

  localparam logic [5:0] LAST_SECOND = 6'd59;
  localparam logic [5:0] LAST_MINUTE = 6'd59;
  localparam logic [4:0] LAST_HOUR   = 5'd23;
  localparam logic [6:0] HOURS_PER_DAY = 7'd24;

  localparam logic [1:0] DONE_NONE = 2'd0;
  localparam logic [1:0] DONE_TIME = 2'd1;
  localparam logic [1:0] DONE_TEXT = 2'd2;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_TICK,
    OP_TIME,
    OP_TEXT
  } op_kind_t;

  typedef struct packed {
    op_kind_t                          op;
    logic [4:0]                        hours;
    logic [5:0]                        minutes;
    logic [5:0]                        seconds;
    logic [LABEL_CHARS-1:0]            text_mask;
    logic [LABEL_CHARS-1:0][7:0]       text;
  } cmd_t;

endpackage

[sv/scc_front.sv]
// Front end: accepts items, collects the command line and decodes finished lines.
// Emits one decoded command per item into the queue. Depends on scc_pkg.
module scc_front #(
  parameter int LINE_CAPACITY = scc_pkg::LINE_CAPACITY_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          kind,
  input  logic [7:0]    rx_byte,
  input  logic          full,
  output logic          push,
  output scc_pkg::cmd_t cmd
);
  import scc_pkg::*;

  localparam int LEN_W = $clog2(LINE_CAPACITY);

  logic [LEN_W-1:0]           line_length;
  logic [KEPT_BYTES-1:0][7:0] line_prefix;
  logic [KEPT_BYTES-1:0]      alive;
  logic [KEPT_BYTES-1:0][7:0] content;
  logic                       run;
  logic                       accept;
  logic                       is_eol;
  logic                       time_key_hit;
  logic                       text_key_hit;
  logic                       digits_ok;
  logic [7:0]                 d [8];
  logic [6:0]                 hh;
  logic [6:0]                 mm;
  logic [6:0]                 ss;

  function automatic logic in_range(logic [7:0] c, logic [7:0] lo, logic [7:0] hi);
    return (c >= lo) && (c <= hi);
  endfunction

  function automatic logic [6:0] two_digits(logic [7:0] tens, logic [7:0] units);
    return 7'(tens[3:0]) * 7'd10 + 7'(units[3:0]);
  endfunction

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;
  assign push     = accept;
  assign is_eol   = (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF);

  // Content ends at the first zero byte or at the stored length.
  always_comb begin
    run   = 1'b1;
    alive = '0;
    for (int i = 0; i < KEPT_BYTES; i++) begin
      run      = run && (LEN_W'(i) < line_length) && (line_prefix[i] != 8'h00);
      alive[i] = run;
      content[i] = alive[i] ? line_prefix[i] : 8'h00;
    end
  end

  always_comb begin
    time_key_hit = 1'b1;
    for (int i = 0; i < TIME_KEY_LEN; i++) begin
      time_key_hit = time_key_hit && (content[i] == TIME_KEY[i]);
    end
    text_key_hit = 1'b1;
    for (int i = 0; i < TEXT_KEY_LEN; i++) begin
      text_key_hit = text_key_hit && (content[i] == TEXT_KEY[i]);
    end
    for (int k = 0; k < 8; k++) begin
      d[k] = content[TIME_KEY_LEN + k];
    end
  end

  assign hh = two_digits(d[0], d[1]);
  assign mm = two_digits(d[3], d[4]);
  assign ss = two_digits(d[6], d[7]);

  assign digits_ok = in_range(d[0], CHAR_ZERO, CHAR_TWO) && in_range(d[1], CHAR_ZERO, CHAR_NINE)
                  && (d[2] == CHAR_COLON)
                  && in_range(d[3], CHAR_ZERO, CHAR_FIVE) && in_range(d[4], CHAR_ZERO, CHAR_NINE)
                  && (d[5] == CHAR_COLON)
                  && in_range(d[6], CHAR_ZERO, CHAR_FIVE) && in_range(d[7], CHAR_ZERO, CHAR_NINE)
                  && (hh < HOURS_PER_DAY);

  always_comb begin
    cmd           = '0;
    cmd.op        = OP_NONE;
    cmd.hours     = hh[4:0];
    cmd.minutes   = mm[5:0];
    cmd.seconds   = ss[5:0];
    for (int i = 0; i < LABEL_CHARS; i++) begin
      cmd.text[i]      = content[TEXT_KEY_LEN + i];
      cmd.text_mask[i] = content[TEXT_KEY_LEN + i] != 8'h00;
    end
    if (kind) begin
      cmd.op = OP_TICK;
    end else if (is_eol && (line_length != '0)) begin
      if (time_key_hit) begin
        if (digits_ok) begin
          cmd.op = OP_TIME;
        end
      end else if (text_key_hit) begin
        cmd.op = OP_TEXT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= '0;
    end else if (accept && !kind) begin
      if (is_eol) begin
        line_length <= '0;
      end else if (line_length < LEN_W'(LINE_CAPACITY - 1)) begin
        line_length <= line_length + 1'b1;
      end
    end
  end

  // Keep only the first bytes of the line; later ones are counted but dropped.
  always_ff @(posedge clk) begin
    if (accept && !kind && !is_eol && (line_length < LEN_W'(KEPT_BYTES))) begin
      line_prefix[line_length[$clog2(KEPT_BYTES)-1:0]] <= rx_byte;
    end
  end

endmodule

[sv/scc_queue.sv]
// Short command queue between the front end and the back end.
// Register-based FIFO of decoded commands. Depends on scc_pkg.
module scc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  scc_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output scc_pkg::cmd_t pop_data,
  output logic          empty
);
  import scc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = count == CNT_W'(QUEUE_DEPTH);
  assign empty    = count == '0;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

[sv/scc_back.sv]
// Back end: applies decoded commands to the clock and label, and holds the result.
// The state registers double as the output register. Depends on scc_pkg.
module scc_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          empty,
  input  scc_pkg::cmd_t cmd,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [4:0]    hours,
  output logic [5:0]    minutes,
  output logic [5:0]    seconds,
  output logic [7:0]    label_first,
  output logic [7:0]    label_second,
  output logic [7:0]    label_third,
  output logic [1:0]    command_done
);
  import scc_pkg::*;

  logic [LABEL_CHARS-1:0][7:0] label;

  // Advance only when the previous result is gone or leaving now.
  assign pop = !empty && (!out_valid || out_ready);

  assign label_first  = label[0];
  assign label_second = label[1];
  assign label_third  = label[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      hours        <= '0;
      minutes      <= '0;
      seconds      <= '0;
      label        <= {LABEL_CHARS{CHAR_DASH}};
      command_done <= DONE_NONE;
    end else begin
      if (pop) begin
        out_valid    <= 1'b1;
        command_done <= DONE_NONE;
        case (cmd.op)
          OP_TICK: begin
            if (seconds == LAST_SECOND) begin
              seconds <= '0;
              if (minutes == LAST_MINUTE) begin
                minutes <= '0;
                hours   <= (hours == LAST_HOUR) ? '0 : hours + 1'b1;
              end else begin
                minutes <= minutes + 1'b1;
              end
            end else begin
              seconds <= seconds + 1'b1;
            end
          end
          OP_TIME: begin
            hours        <= cmd.hours;
            minutes      <= cmd.minutes;
            seconds      <= cmd.seconds;
            command_done <= DONE_TIME;
          end
          OP_TEXT: begin
            for (int i = 0; i < LABEL_CHARS; i++) begin
              if (cmd.text_mask[i]) begin
                label[i] <= cmd.text[i];
              end
            end
            command_done <= DONE_TEXT;
          end
          default: begin
            command_done <= DONE_NONE;
          end
        endcase
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[sv/serial_command_clock.sv]
// Serial command clock: time of day plus a three-character label.
// Throughput: one item per cycle while the queue has room; the front end decodes
// a whole line in the cycle its CR or LF is accepted, and the back end applies one
// command per cycle unless the receiver holds off results. Decode and queue write
// happen at the accepting edge; the back end registers the result once it pops it.
// Reset: synchronous; clears the line, the clock to 00:00:00 and the label to dashes.
// Depends on scc_pkg, scc_front, scc_queue and scc_back.
module serial_command_clock #(
  parameter int LINE_CAPACITY = scc_pkg::LINE_CAPACITY_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       kind,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [4:0] hours,
  output logic [5:0] minutes,
  output logic [5:0] seconds,
  output logic [7:0] label_first,
  output logic [7:0] label_second,
  output logic [7:0] label_third,
  output logic [1:0] command_done
);
  import scc_pkg::*;

  cmd_t front_cmd;
  cmd_t head_cmd;
  logic push;
  logic pop;
  logic full;
  logic empty;

  scc_front #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .rx_byte  (rx_byte),
    .full     (full),
    .push     (push),
    .cmd      (front_cmd)
  );

  scc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_cmd),
    .full      (full),
    .pop       (pop),
    .pop_data  (head_cmd),
    .empty     (empty)
  );

  scc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (empty),
    .cmd          (head_cmd),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hours        (hours),
    .minutes      (minutes),
    .seconds      (seconds),
    .label_first  (label_first),
    .label_second (label_second),
    .label_third  (label_third),
    .command_done (command_done)
  );

endmodule

[tb/scc_checker.sv]
// Checker for serial_command_clock: watches both channels, predicts every result
// from its own copy of the clock, label and line state, and compares in order.
// Depends on scc_pkg.
module scc_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic       kind,
  input  logic [7:0] rx_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [4:0] hours,
  input  logic [5:0] minutes,
  input  logic [5:0] seconds,
  input  logic [7:0] label_first,
  input  logic [7:0] label_second,
  input  logic [7:0] label_third,
  input  logic [1:0] command_done,
  output int         error_count,
  output int         pending_results
);
  timeunit 1ns;
  timeprecision 1ps;
  import scc_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [7:0] first_char;
    logic [7:0] second_char;
    logic [7:0] third_char;
    logic [1:0] done;
  } clock_view_t;

  clock_view_t expected_views[$];

  logic [7:0] line_bytes [KEPT_BYTES];
  int         line_len;
  logic [4:0] hour_q;
  logic [5:0] min_q;
  logic [5:0] sec_q;
  logic [7:0] label_q [LABEL_CHARS];

  // Apply one transaction to the shadow state and return the view that follows it.
  function automatic clock_view_t predict_view(input logic is_tick, input logic [7:0] b);
    logic [7:0]  content [KEPT_BYTES];
    int          content_len;
    int          limit;
    int          hh;
    logic        time_hit;
    logic        text_hit;
    logic        digits_ok;
    logic [1:0]  done;
    clock_view_t v;
    done = DONE_NONE;
    if (is_tick) begin
      sec_q = sec_q + 6'd1;
      if (sec_q > LAST_SECOND) begin
        sec_q = '0;
        min_q = min_q + 6'd1;
      end
      if (min_q > LAST_MINUTE) begin
        min_q  = '0;
        hour_q = hour_q + 5'd1;
      end
      if (hour_q > LAST_HOUR) hour_q = '0;
    end else if (b == CHAR_CR || b == CHAR_LF) begin
      if (line_len > 0) begin
        limit = (line_len < KEPT_BYTES) ? line_len : KEPT_BYTES;
        content_len = 0;
        while (content_len < limit && line_bytes[content_len] != 8'h00) content_len++;
        // Positions past the content end read as zero, never as stale bytes.
        for (int i = 0; i < KEPT_BYTES; i++)
          content[i] = (i < content_len) ? line_bytes[i] : 8'h00;
        time_hit = 1'b1;
        for (int i = 0; i < TIME_KEY_LEN; i++)
          if (content[i] != TIME_KEY[i]) time_hit = 1'b0;
        text_hit = 1'b1;
        for (int i = 0; i < TEXT_KEY_LEN; i++)
          if (content[i] != TEXT_KEY[i]) text_hit = 1'b0;
        if (time_hit) begin
          digits_ok = content[8]  >= CHAR_ZERO && content[8]  <= CHAR_TWO  &&
                      content[9]  >= CHAR_ZERO && content[9]  <= CHAR_NINE &&
                      content[10] == CHAR_COLON &&
                      content[11] >= CHAR_ZERO && content[11] <= CHAR_FIVE &&
                      content[12] >= CHAR_ZERO && content[12] <= CHAR_NINE &&
                      content[13] == CHAR_COLON &&
                      content[14] >= CHAR_ZERO && content[14] <= CHAR_FIVE &&
                      content[15] >= CHAR_ZERO && content[15] <= CHAR_NINE;
          hh = (content[8] - CHAR_ZERO) * 10 + (content[9] - CHAR_ZERO);
          if (digits_ok && hh < HOURS_PER_DAY) begin
            hour_q = 5'(hh);
            min_q  = 6'((content[11] - CHAR_ZERO) * 10 + (content[12] - CHAR_ZERO));
            sec_q  = 6'((content[14] - CHAR_ZERO) * 10 + (content[15] - CHAR_ZERO));
            done   = DONE_TIME;
          end
        end else if (text_hit) begin
          for (int i = 0; i < LABEL_CHARS; i++)
            if (content[TEXT_KEY_LEN + i] != 8'h00) label_q[i] = content[TEXT_KEY_LEN + i];
          done = DONE_TEXT;
        end
        line_len = 0;
      end
    end else if (line_len < LINE_CAPACITY_DEFAULT - 1) begin
      // Keep only the head of the line; count the rest up to capacity.
      if (line_len < KEPT_BYTES) line_bytes[line_len] = b;
      line_len++;
    end
    v.hours       = hour_q;
    v.minutes     = min_q;
    v.seconds     = sec_q;
    v.first_char  = label_q[0];
    v.second_char = label_q[1];
    v.third_char  = label_q[2];
    v.done        = done;
    return v;
  endfunction

  always @(posedge clk) begin : watch
    clock_view_t seen;
    clock_view_t want;
    if (rst) begin
      expected_views.delete();
      for (int i = 0; i < KEPT_BYTES; i++) line_bytes[i] = 8'h00;
      line_len = 0;
      hour_q   = '0;
      min_q    = '0;
      sec_q    = '0;
      for (int i = 0; i < LABEL_CHARS; i++) label_q[i] = CHAR_DASH;
      pending_results = 0;
    end else begin
      if (out_valid && out_ready) begin
        seen = {hours, minutes, seconds, label_first, label_second, label_third,
                command_done};
        if (expected_views.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("%0t: result %0d:%0d:%0d '%h %h %h' done %0d with nothing expected",
                     $realtime, hours, minutes, seconds, label_first, label_second,
                     label_third, command_done);
        end else begin
          want = expected_views.pop_front();
          if (seen !== want) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
              $display("%0t: mismatch expected %0d:%0d:%0d '%h %h %h' done %0d, got %0d:%0d:%0d '%h %h %h' done %0d",
                       $realtime, want.hours, want.minutes, want.seconds,
                       want.first_char, want.second_char, want.third_char, want.done,
                       seen.hours, seen.minutes, seen.seconds, seen.first_char,
                       seen.second_char, seen.third_char, seen.done);
          end
        end
      end
      if (in_valid && in_ready) expected_views.push_back(predict_view(kind, rx_byte));
      pending_results = expected_views.size();
    end
  end

endmodule

[tb/testbench.sv]
// Top of the serial_command_clock testbench: clock, reset, command-line and tick
// stimulus, receiver back-pressure and the verdict. Depends on scc_pkg,
// serial_command_clock and scc_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import scc_pkg::*;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;
  localparam logic [7:0] NUL_BYTE = 8'h00;
  localparam int RANDOM_ITEMS = 400;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 20;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic       kind;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic [4:0] hours;
  logic [5:0] minutes;
  logic [5:0] seconds;
  logic [7:0] label_first;
  logic [7:0] label_second;
  logic [7:0] label_third;
  logic [1:0] command_done;
  int         error_count;
  int         pending_results;

  logic [7:0] line_buf[$];
  int         items_sent;
  bit         no_gaps;
  bit         hold_outputs;

  serial_command_clock u_dut (.*);
  scc_checker u_check (.*);

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  // Offer one transaction and hold it until accepted, then maybe idle.
  task automatic send_item(input logic k, input logic [7:0] b);
    int gap;
    int r;
    @(negedge clk);
    in_valid = 1'b1;
    kind     = k;
    rx_byte  = b;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 10);
    else gap = $urandom_range(20, 40);
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      kind     = 1'($urandom);
      rx_byte  = 8'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic send_buffer();
    while (line_buf.size() > 0) send_item(KIND_BYTE, line_buf.pop_front());
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] random_char();
    logic [7:0] c;
    do c = 8'($urandom); while (c == CHAR_CR || c == CHAR_LF);
    return c;
  endfunction

  function automatic logic [7:0] line_end();
    return $urandom_range(0, 1) ? CHAR_CR : CHAR_LF;
  endfunction

  // Stall the receiver while bytes keep coming, so the block backs up.
  task automatic overfill_block();
    bit saved;
    saved        = no_gaps;
    no_gaps      = 1'b1;
    hold_outputs = 1'b1;
    while (hold_outputs) send_item(KIND_BYTE, random_char());
    send_item(KIND_BYTE, CHAR_LF);
    no_gaps = saved;
  endtask

  initial begin : receiver
    int n;
    int r;
    out_ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (hold_outputs) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_outputs = 1'b0;
      end
      out_ready = 1'b1;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      repeat (n) @(negedge clk);
      r = $urandom_range(0, 99);
      if (r < 40) n = 0;
      else if (r < 85) n = $urandom_range(1, 3);
      else if (r < 95) n = $urandom_range(4, 10);
      else n = $urandom_range(20, 40);
      if (n > 0) begin
        out_ready = 1'b0;
        repeat (n) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    int    hh;
    int    mm;
    int    ss;
    int    sel;
    int    start;
    int    p;
    string key;
    bit    mid_hold_done;
    rst           = 1'b1;
    in_valid      = 1'b0;
    kind          = KIND_BYTE;
    rx_byte       = 8'h00;
    items_sent    = 0;
    no_gaps       = 1'b0;
    hold_outputs  = 1'b0;
    mid_hold_done = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Ticks ignore the byte field.
    send_item(KIND_TICK, 8'h00);
    send_item(KIND_TICK, 8'hFF);
    // Full-day wrap, then the lowest time.
    put_text("SETTIME=23:59:59"); line_buf.push_back(CHAR_CR); send_buffer();
    send_item(KIND_TICK, 8'h5A);
    put_text("SETTIME=00:00:00"); line_buf.push_back(CHAR_LF); send_buffer();
    // Rejected times: hour too big, minute tens too big, bad separator, short line.
    put_text("SETTIME=24:00:00"); line_buf.push_back(CHAR_LF); send_buffer();
    put_text("SETTIME=12:60:00"); line_buf.push_back(CHAR_CR); send_buffer();
    put_text("SETTIME=12-34:56"); line_buf.push_back(CHAR_LF); send_buffer();
    put_text("SETTIME=1"); line_buf.push_back(CHAR_CR); send_buffer();
    // Trailing text after the seconds is ignored.
    put_text("SETTIME=12:34:56ZZ"); line_buf.push_back(CHAR_LF); send_buffer();
    // Label: full, partial, empty, cut by a zero byte.
    put_text("SETTXT=abc"); line_buf.push_back(CHAR_LF); send_buffer();
    put_text("SETTXT=Q"); line_buf.push_back(CHAR_CR); send_buffer();
    put_text("SETTXT="); line_buf.push_back(CHAR_LF); send_buffer();
    put_text("SETTXT=x"); line_buf.push_back(NUL_BYTE); put_text("yz");
    line_buf.push_back(CHAR_LF); send_buffer();
    // Empty lines do nothing.
    send_item(KIND_BYTE, CHAR_CR);
    send_item(KIND_BYTE, CHAR_LF);
    // Overflowing line still decodes its head.
    put_text("SETTXT=<>#");
    repeat (70) line_buf.push_back(8'h80);
    line_buf.push_back(CHAR_LF); send_buffer();
    // Unknown and truncated keys.
    put_text("HELLO"); line_buf.push_back(CHAR_LF); send_buffer();
    put_text("SETTIM"); line_buf.push_back(CHAR_CR); send_buffer();
    wait_drained();

    overfill_block();
    wait_drained();

    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      if (!mid_hold_done && items_sent - start > RANDOM_ITEMS / 2) begin
        mid_hold_done = 1'b1;
        overfill_block();
      end
      if ($urandom_range(0, 9) == 0) no_gaps = ~no_gaps;
      if ($urandom_range(0, 39) == 0) wait_drained();
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
        put_text("SETTIME=");
        hh = ($urandom_range(0, 9) == 0) ? $urandom_range(24, 29) : $urandom_range(0, 23);
        mm = $urandom_range(0, 59);
        ss = $urandom_range(0, 59);
        line_buf.push_back(8'(CHAR_ZERO + hh / 10));
        line_buf.push_back(8'(CHAR_ZERO + hh % 10));
        line_buf.push_back(CHAR_COLON);
        line_buf.push_back(8'(CHAR_ZERO + mm / 10));
        line_buf.push_back(8'(CHAR_ZERO + mm % 10));
        line_buf.push_back(CHAR_COLON);
        line_buf.push_back(8'(CHAR_ZERO + ss / 10));
        line_buf.push_back(8'(CHAR_ZERO + ss % 10));
        if ($urandom_range(0, 3) == 0) line_buf[$urandom_range(0, 15)] = random_char();
        repeat ($urandom_range(0, 2)) line_buf.push_back(random_char());
        line_buf.push_back(line_end());
        send_buffer();
      end else if (sel < 50) begin
        put_text("SETTXT=");
        repeat ($urandom_range(0, 5))
          line_buf.push_back(($urandom_range(0, 9) == 0) ? NUL_BYTE : random_char());
        line_buf.push_back(line_end());
        send_buffer();
      end else if (sel < 60) begin
        repeat ($urandom_range(1, 8)) send_item(KIND_TICK, 8'($urandom));
      end else if (sel < 65) begin
        // Land near a minute or day boundary, then tick across it.
        put_text($urandom_range(0, 1) ? "SETTIME=23:59:5" : "SETTIME=07:59:5");
        line_buf.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
        line_buf.push_back(line_end());
        send_buffer();
        repeat ($urandom_range(5, 15)) send_item(KIND_TICK, 8'($urandom));
      end else if (sel < 80) begin
        key = $urandom_range(0, 1) ? "SETTIME=" : "SETTXT=";
        p = $urandom_range(0, key.len() - 1);
        for (int i = 0; i < key.len(); i++)
          if (i != p) line_buf.push_back(key[i]);
          else if ($urandom_range(0, 1)) line_buf.push_back(random_char());
        repeat ($urandom_range(0, 9)) line_buf.push_back(random_char());
        line_buf.push_back(line_end());
        send_buffer();
      end else if (sel < 90) begin
        repeat ($urandom_range(1, 20)) line_buf.push_back(8'($urandom));
        send_buffer();
      end else if (sel < 95) begin
        if ($urandom_range(0, 1)) put_text("SETTXT=");
        repeat ($urandom_range(20, 80)) line_buf.push_back(random_char());
        line_buf.push_back(line_end());
        send_buffer();
      end else begin
        // Ticks in the middle of a line leave the line alone.
        put_text("SETTXT=");
        send_buffer();
        send_item(KIND_TICK, 8'($urandom));
        repeat ($urandom_range(1, 3)) line_buf.push_back(random_char());
        line_buf.push_back(line_end());
        send_buffer();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pending_results != 0) $display("%0d results never arrived", pending_results);
    if (error_count == 0 && pending_results == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
sv/scc_pkg.sv
sv/scc_front.sv
sv/scc_queue.sv
sv/scc_back.sv
sv/serial_command_clock.sv
tb/scc_checker.sv
tb/testbench.sv
